>>> design/srg_pkg.sv
// srg_pkg: constants, types and helper functions for the subtractive generator
// used by the interfaces, the table memory, the remainder unit and the top level
package srg_pkg;

	localparam int WORD_W        = 31;
	localparam int TABLE_LEN     = 55;
	localparam int ADDR_W        = $clog2(TABLE_LEN);
	localparam int SEED_STRIDE   = 21;
	localparam int MIX_LAG       = 30;
	localparam int MIX_OFS       = MIX_LAG + 1;
	localparam int PARTNER_START = 31;
	localparam int MIX_PASSES    = 4;
	localparam int PASS_W        = $clog2(MIX_PASSES);
	localparam int DIV_CNT_W     = $clog2(WORD_W + 1);
	localparam int CFG_IDX_W     = 2;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [ADDR_W-1:0] addr_t;

	localparam logic [CFG_IDX_W-1:0] CFG_MODULUS      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEED_OFFSET  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_SEED = 2'd2;

	localparam logic REQ_DRAW   = 1'b0;
	localparam logic REQ_RESEED = 1'b1;

	localparam word_t MODULUS_RST      = 31'd1000000000;
	localparam word_t SEED_OFFSET_RST  = 31'd161803398;
	localparam word_t INITIAL_SEED_RST = 31'd1;

	typedef struct packed {
		logic  en;
		addr_t addr_a;
		addr_t addr_b;
	} ram_rd_t;

	typedef struct packed {
		logic  en;
		addr_t addr;
		word_t data;
	} ram_wr_t;

	typedef struct packed {
		logic  start;
		word_t dividend;
	} rem_ctrl_t;

	typedef struct packed {
		logic  done;
		word_t rem;
	} rem_stat_t;

	function automatic word_t eff_mod(input word_t m);
		return (m < word_t'(2)) ? word_t'(2) : m;
	endfunction

	// difference modulo m, m added once when negative, wraps at word width
	function automatic word_t sub_mod(input word_t a, input word_t b, input word_t m);
		word_t d;
		d = a - b;
		if (a < b) begin
			d = d + m;
		end
		return d;
	endfunction

	function automatic addr_t advance(input addr_t p);
		return (p >= addr_t'(TABLE_LEN)) ? addr_t'(1) : p + addr_t'(1);
	endfunction

endpackage

>>> design/srg_if.sv
// srg_if: valid/ready channels for request and response beats
// depends on srg_pkg for the word type
interface srg_req_if;
	logic                 valid;
	logic                 ready;
	logic                 req_type;
	srg_pkg::word_t       seed;

	modport source (output valid, output req_type, output seed, input ready);
	modport sink (input valid, input req_type, input seed, output ready);
endinterface

interface srg_rsp_if;
	logic                 valid;
	logic                 ready;
	srg_pkg::word_t       value;
	srg_pkg::word_t       partner_word;

	modport source (output valid, output value, output partner_word, input ready);
	modport sink (input valid, input value, input partner_word, output ready);
endinterface

>>> design/srg_table_ram.sv
// srg_table_ram: 55-word lag table, one write port and two registered read ports
// depends on srg_pkg for the depth, word type and port structs
module srg_table_ram (
	input  logic              clk,
	input  srg_pkg::ram_rd_t  rd,
	input  srg_pkg::ram_wr_t  wr,
	output srg_pkg::word_t    rd_data_a,
	output srg_pkg::word_t    rd_data_b
);

	srg_pkg::word_t mem [srg_pkg::TABLE_LEN];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data_a <= mem[rd.addr_a];
			rd_data_b <= mem[rd.addr_b];
		end
	end

endmodule

>>> design/srg_rem_unit.sv
// srg_rem_unit: bit-serial restoring remainder, one dividend bit per cycle
// depends on srg_pkg for the word type and control structs
module srg_rem_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  srg_pkg::rem_ctrl_t  ctrl,
	input  srg_pkg::word_t      divisor,
	output srg_pkg::rem_stat_t  stat
);

	logic [srg_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          done_q;
	srg_pkg::word_t                dvd_q;
	srg_pkg::word_t                rem_q;
	logic [srg_pkg::WORD_W:0]      trial;
	srg_pkg::word_t                trial_sub;

	assign trial     = {rem_q, dvd_q[srg_pkg::WORD_W-1]};
	assign trial_sub = trial[srg_pkg::WORD_W-1:0] - divisor;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == srg_pkg::DIV_CNT_W'(1));
			if (ctrl.start) begin
				cnt_q <= srg_pkg::DIV_CNT_W'(srg_pkg::WORD_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - srg_pkg::DIV_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			dvd_q <= ctrl.dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[srg_pkg::WORD_W-2:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				rem_q <= trial_sub;
			end else begin
				rem_q <= trial[srg_pkg::WORD_W-1:0];
			end
		end
	end

	assign stat.done = done_q;
	assign stat.rem  = rem_q;

endmodule

>>> design/subtractive_random_generator_top.sv
// subtractive_random_generator_top: sequencer, config registers and output register
// depends on srg_pkg, srg_if, srg_table_ram and srg_rem_unit
// draw: the request beat issues two table reads, and S_DRAW does the write-back and result load
// once the output register is free; no new request is taken until the draw has finished
// seeding: serial remainder, 54 fill writes, 4 x 55 read/write mixes
// reset: config registers to defaults, indices 0 and 31, table undefined until seeded
module subtractive_random_generator_top (
	input  logic                              clk,
	input  logic                              arst_n,
	srg_req_if.sink                           req,
	srg_rsp_if.source                         rsp,
	input  logic                              cfg_we,
	input  logic [srg_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  srg_pkg::word_t                    cfg_wdata
);

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_DRAW    = 7'b0000010,
		S_DIV     = 7'b0000100,
		S_FILL    = 7'b0001000,
		S_MIX_RD  = 7'b0010000,
		S_MIX_WR  = 7'b0100000,
		S_DRAW_RD = 7'b1000000
	} state_t;

	state_t                       state_q;
	srg_pkg::word_t               modulus_q;
	srg_pkg::word_t               seed_offset_q;
	srg_pkg::word_t               initial_seed_q;
	srg_pkg::addr_t               r_q;
	srg_pkg::addr_t               pt_q;
	logic                         init_q;
	logic                         out_valid_q;
	srg_pkg::addr_t               idx_q;
	srg_pkg::addr_t               cnt_q;
	logic [srg_pkg::PASS_W-1:0]   pass_q;
	srg_pkg::word_t               prev_q;
	srg_pkg::word_t               cur_q;
	srg_pkg::word_t               value_q;
	srg_pkg::word_t               partner_q;

	srg_pkg::word_t               m_eff;
	srg_pkg::addr_t               adv_r;
	srg_pkg::addr_t               adv_pt;
	logic                         accept;
	logic                         draw_now;
	logic                         seed_now;
	logic                         out_free;
	srg_pkg::word_t               rd_a;
	srg_pkg::word_t               rd_b;
	srg_pkg::word_t               rd_diff;
	srg_pkg::word_t               seed_sel;
	srg_pkg::addr_t               mix_q_addr;
	srg_pkg::addr_t               fill_next;
	logic [srg_pkg::ADDR_W:0]     mix_sum;
	logic [srg_pkg::ADDR_W:0]     fill_sum;
	srg_pkg::ram_rd_t             ram_rd;
	srg_pkg::ram_wr_t             ram_wr;
	srg_pkg::rem_ctrl_t           rem_ctrl;
	srg_pkg::rem_stat_t           rem_stat;

	assign m_eff    = srg_pkg::eff_mod(modulus_q);
	assign adv_r    = srg_pkg::advance(r_q);
	assign adv_pt   = srg_pkg::advance(pt_q);
	assign req.ready = (state_q == S_IDLE);
	assign accept   = req.valid && req.ready;
	assign draw_now = accept && (req.req_type == srg_pkg::REQ_DRAW) && init_q;
	assign seed_now = accept && !draw_now;
	assign out_free = !out_valid_q || rsp.ready;
	assign rd_diff  = srg_pkg::sub_mod(rd_a, rd_b, m_eff);
	assign seed_sel = (req.req_type == srg_pkg::REQ_RESEED) ? req.seed : initial_seed_q;

	assign mix_sum    = {1'b0, idx_q} + (srg_pkg::ADDR_W+1)'(srg_pkg::MIX_OFS);
	assign mix_q_addr = (mix_sum >= (srg_pkg::ADDR_W+1)'(srg_pkg::TABLE_LEN))
		? srg_pkg::addr_t'(mix_sum - (srg_pkg::ADDR_W+1)'(srg_pkg::TABLE_LEN))
		: mix_sum[srg_pkg::ADDR_W-1:0];
	assign fill_sum   = {1'b0, idx_q} + (srg_pkg::ADDR_W+1)'(srg_pkg::SEED_STRIDE);
	assign fill_next  = (fill_sum >= (srg_pkg::ADDR_W+1)'(srg_pkg::TABLE_LEN))
		? srg_pkg::addr_t'(fill_sum - (srg_pkg::ADDR_W+1)'(srg_pkg::TABLE_LEN))
		: fill_sum[srg_pkg::ADDR_W-1:0];

	always_comb begin
		rem_ctrl.start    = seed_now;
		rem_ctrl.dividend = (seed_offset_q >= seed_sel) ? seed_offset_q - seed_sel
			: seed_sel - seed_offset_q;
	end

	always_comb begin
		ram_rd = '0;
		ram_wr = '0;
		case (state_q)
			S_IDLE: begin
				ram_rd.en     = draw_now;
				ram_rd.addr_a = adv_r - srg_pkg::addr_t'(1);
				ram_rd.addr_b = adv_pt - srg_pkg::addr_t'(1);
			end
			S_DRAW_RD: begin
				ram_rd.en     = 1'b1;
				ram_rd.addr_a = adv_r - srg_pkg::addr_t'(1);
				ram_rd.addr_b = adv_pt - srg_pkg::addr_t'(1);
			end
			S_DRAW: begin
				ram_wr.en   = out_free;
				ram_wr.addr = r_q - srg_pkg::addr_t'(1);
				ram_wr.data = rd_diff;
			end
			S_DIV: begin
				ram_wr.en   = rem_stat.done;
				ram_wr.addr = srg_pkg::addr_t'(srg_pkg::TABLE_LEN - 1);
				ram_wr.data = rem_stat.rem;
			end
			S_FILL: begin
				ram_wr.en   = 1'b1;
				ram_wr.addr = idx_q;
				ram_wr.data = cur_q;
			end
			S_MIX_RD: begin
				ram_rd.en     = 1'b1;
				ram_rd.addr_a = idx_q;
				ram_rd.addr_b = mix_q_addr;
			end
			S_MIX_WR: begin
				ram_wr.en   = 1'b1;
				ram_wr.addr = idx_q;
				ram_wr.data = rd_diff;
			end
			default: begin
				ram_rd = '0;
				ram_wr = '0;
			end
		endcase
	end

	srg_table_ram u_table (
		.clk       (clk),
		.rd        (ram_rd),
		.wr        (ram_wr),
		.rd_data_a (rd_a),
		.rd_data_b (rd_b)
	);

	srg_rem_unit u_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (rem_ctrl),
		.divisor (m_eff),
		.stat    (rem_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q      <= srg_pkg::MODULUS_RST;
			seed_offset_q  <= srg_pkg::SEED_OFFSET_RST;
			initial_seed_q <= srg_pkg::INITIAL_SEED_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				srg_pkg::CFG_MODULUS:      modulus_q      <= cfg_wdata;
				srg_pkg::CFG_SEED_OFFSET:  seed_offset_q  <= cfg_wdata;
				srg_pkg::CFG_INITIAL_SEED: initial_seed_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			r_q         <= '0;
			pt_q        <= srg_pkg::addr_t'(srg_pkg::PARTNER_START);
			init_q      <= 1'b0;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			cnt_q       <= '0;
			pass_q      <= '0;
		end else begin
			if (state_q == S_DRAW && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (draw_now) begin
						r_q     <= adv_r;
						pt_q    <= adv_pt;
						state_q <= S_DRAW;
					end else if (seed_now) begin
						state_q <= S_DIV;
					end
				end
				S_DRAW: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_DIV: begin
					if (rem_stat.done) begin
						idx_q   <= srg_pkg::addr_t'(srg_pkg::SEED_STRIDE - 1);
						cnt_q   <= srg_pkg::addr_t'(1);
						state_q <= S_FILL;
					end
				end
				S_FILL: begin
					cnt_q <= cnt_q + srg_pkg::addr_t'(1);
					if (cnt_q == srg_pkg::addr_t'(srg_pkg::TABLE_LEN - 1)) begin
						idx_q   <= '0;
						pass_q  <= '0;
						state_q <= S_MIX_RD;
					end else begin
						idx_q <= fill_next;
					end
				end
				S_MIX_RD: begin
					state_q <= S_MIX_WR;
				end
				S_MIX_WR: begin
					if (idx_q == srg_pkg::addr_t'(srg_pkg::TABLE_LEN - 1)) begin
						idx_q  <= '0;
						pass_q <= pass_q + srg_pkg::PASS_W'(1);
						if (pass_q == srg_pkg::PASS_W'(srg_pkg::MIX_PASSES - 1)) begin
							init_q  <= 1'b1;
							r_q     <= '0;
							pt_q    <= srg_pkg::addr_t'(srg_pkg::PARTNER_START);
							state_q <= S_DRAW_RD;
						end else begin
							state_q <= S_MIX_RD;
						end
					end else begin
						idx_q   <= idx_q + srg_pkg::addr_t'(1);
						state_q <= S_MIX_RD;
					end
				end
				S_DRAW_RD: begin
					r_q     <= adv_r;
					pt_q    <= adv_pt;
					state_q <= S_DRAW;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DIV && rem_stat.done) begin
			prev_q <= rem_stat.rem;
			cur_q  <= srg_pkg::word_t'(1);
		end else if (state_q == S_FILL) begin
			cur_q  <= srg_pkg::sub_mod(prev_q, cur_q, m_eff);
			prev_q <= cur_q;
		end
		if (state_q == S_DRAW && out_free) begin
			value_q   <= rd_diff;
			partner_q <= rd_b;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.value        = value_q;
	assign rsp.partner_word = partner_q;

endmodule
